// File: rtl/core/qta_pkg.sv
// Shared types and constants of the quadtree atlas allocator.
// Sizes of the flag tree, request/response transaction structs, codes.
// No dependencies.
`default_nettype none

package qta_pkg;

  localparam int AtlasLog2   = 11;
  localparam int MinNodeLog2 = 7;
  localparam int TreeLevels  = AtlasLog2 - MinNodeLog2;
  localparam int NodeCount   = ((1 << (2 * TreeLevels + 2)) - 1) / 3;

  localparam int IdxW   = $clog2(NodeCount);
  localparam int DepthW = $clog2(TreeLevels + 1);
  localparam int PosW   = 11;
  localparam int SizeW  = 4;

  typedef logic [1:0] flags_t;

  localparam flags_t FlagsEmpty = 2'b01;
  localparam flags_t FlagsFull  = 2'b10;

  typedef enum logic {
    OpAlloc   = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSpace  = 2'd1,
    StBadSize  = 2'd2,
    StNotAlloc = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [SizeW-1:0] req_size_log2;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] res_x;
    logic [PosW-1:0] res_y;
    logic [8:0]      node_index;
  } rsp_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    flags_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    SqClear,
    SqIdle,
    SqDesc,
    SqRead,
    SqCheck,
    SqFail,
    SqUp,
    SqChild,
    SqDone
  } seq_e;

endpackage

`default_nettype wire

// File: rtl/core/quadtree_atlas_allocator_top.sv
// Quadtree atlas allocator: hands out and takes back square power-of-two
// regions of a 2048x2048 atlas, from 128 texels up to the whole atlas.
// Request channel (in_valid_i/in_stall_o/in_data_i) takes one transaction:
// allocate a region of edge 2^req_size_log2, or release the region at
// pos_x/pos_y of that size. Response channel (out_valid_o/out_stall_i/
// out_data_o) returns exactly one transaction per request: status, corner
// and tree node index.
// One request is in flight at a time; in_stall_o is high until its response
// is handed to the output register. A bad size or misaligned release goes
// straight to the response. A release descends to its node and reads its
// flags; an allocated node is marked empty, else the response is not-allocated.
// An allocate searches depth first, stepping to the next sibling or back up
// when a node is rejected. When a node is claimed or freed, each ancestor's
// flags are then recomputed from its four children. All steps share the
// single flag memory port.
// After reset the flag memory is swept to all-empty, with in_stall_o high.
// A stalled response holds in the output register while the next request
// is already taken in.
// Depends on qta_pkg, qta_flag_ram, qta_walker, qta_out_buf.
`default_nettype none

module quadtree_atlas_allocator_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire qta_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output qta_pkg::rsp_t      out_data_o
);

  qta_pkg::mem_req_t mem_req;
  qta_pkg::flags_t   mem_rdata;
  logic              rsp_valid;
  logic              rsp_stall;
  qta_pkg::rsp_t     rsp;

  qta_flag_ram u_flag_ram (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  qta_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_data_i),
    .req_stall_o (in_stall_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_stall_i (rsp_stall)
  );

  qta_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rsp_valid),
    .in_data_i   (rsp),
    .in_stall_o  (rsp_stall),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

// File: rtl/core/qta_flag_ram.sv
// Node flag memory: one write port, one read port with registered data.
// Depends on qta_pkg.
`default_nettype none

module qta_flag_ram (
  input  wire logic              clk_i,
  input  wire qta_pkg::mem_req_t mem_i,
  output qta_pkg::flags_t        rdata_o
);

  qta_pkg::flags_t mem_q [qta_pkg::NodeCount];
  qta_pkg::flags_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/qta_walker.sv
// Tree walk sequencer: clear sweep, depth-first allocate search, release
// descent and ancestor flag recompute over the shared flag memory port.
// Depends on qta_pkg.
`default_nettype none

module qta_walker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire qta_pkg::req_t     req_i,
  output logic                   req_stall_o,
  output qta_pkg::mem_req_t      mem_o,
  input  wire qta_pkg::flags_t   mem_rdata_i,
  output logic                   rsp_valid_o,
  output qta_pkg::rsp_t          rsp_o,
  input  wire logic              rsp_stall_i
);

  localparam int IdxW   = qta_pkg::IdxW;
  localparam int DepthW = qta_pkg::DepthW;
  localparam int PosW   = qta_pkg::PosW;
  localparam int SizeW  = qta_pkg::SizeW;

  qta_pkg::seq_e    state_q, state_d;
  qta_pkg::op_e     op_q, op_d;
  qta_pkg::status_e status_q, status_d;
  logic [DepthW-1:0] t_q, t_d, d_q, d_d;
  logic [IdxW-1:0]   idx_q, idx_d, node_q, node_d;
  logic [PosW-1:0]   px_q, px_d, py_q, py_d, x_q, x_d, y_q, y_d;
  logic [2:0]        k_q, k_d;
  logic              acc_empty_q, acc_empty_d, acc_full_q, acc_full_d;

  logic              accept;
  logic              size_bad;
  logic              misalign;
  logic [PosW-1:0]   mask;
  logic [SizeW-1:0]  t_calc;
  logic [IdxW-1:0]   idx_m1;
  logic [1:0]        cur_c;
  logic [IdxW-1:0]   parent;
  logic [IdxW+1:0]   child_base;
  logic [SizeW-1:0]  bit_pos;
  logic [1:0]        desc_c;
  logic [SizeW-1:0]  half_sh;
  logic [PosW-1:0]   half;
  logic              at_target;
  logic              fl_empty, fl_full;

  assign accept   = req_valid_i && (state_q == qta_pkg::SqIdle);
  assign size_bad = (req_i.req_size_log2 < SizeW'(qta_pkg::MinNodeLog2)) ||
                    (req_i.req_size_log2 > SizeW'(qta_pkg::AtlasLog2));

  always_comb begin
    for (int i = 0; i < PosW; i++) begin
      mask[i] = (SizeW'(i) < req_i.req_size_log2);
    end
  end

  assign misalign   = |((req_i.pos_x | req_i.pos_y) & mask);
  assign t_calc     = SizeW'(qta_pkg::AtlasLog2) - req_i.req_size_log2;
  assign idx_m1     = idx_q - IdxW'(1);
  assign cur_c      = idx_m1[1:0];
  assign parent     = IdxW'(idx_m1 >> 2);
  assign child_base = {idx_q, 2'b01};
  assign bit_pos    = SizeW'(qta_pkg::AtlasLog2 - 1) - SizeW'(d_q);
  assign desc_c     = {py_q[bit_pos], px_q[bit_pos]};
  assign half_sh    = SizeW'(qta_pkg::AtlasLog2) - SizeW'(d_q);
  assign half       = PosW'(1) << half_sh;
  assign at_target  = (d_q == t_q);
  assign fl_empty   = mem_rdata_i[0];
  assign fl_full    = mem_rdata_i[1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qta_pkg::SqClear: begin
        if (idx_q == IdxW'(qta_pkg::NodeCount - 1)) state_d = qta_pkg::SqIdle;
      end
      qta_pkg::SqIdle: begin
        if (req_valid_i) begin
          if (size_bad) begin
            state_d = qta_pkg::SqDone;
          end else if (req_i.op == qta_pkg::OpAlloc) begin
            state_d = qta_pkg::SqRead;
          end else if (misalign) begin
            state_d = qta_pkg::SqDone;
          end else begin
            state_d = qta_pkg::SqDesc;
          end
        end
      end
      qta_pkg::SqDesc: begin
        if (at_target) state_d = qta_pkg::SqRead;
      end
      qta_pkg::SqRead: state_d = qta_pkg::SqCheck;
      qta_pkg::SqCheck: begin
        if (op_q == qta_pkg::OpAlloc) begin
          if (fl_full) begin
            state_d = qta_pkg::SqFail;
          end else if (at_target) begin
            state_d = fl_empty ? qta_pkg::SqUp : qta_pkg::SqFail;
          end else begin
            state_d = qta_pkg::SqRead;
          end
        end else begin
          state_d = fl_full ? qta_pkg::SqUp : qta_pkg::SqDone;
        end
      end
      qta_pkg::SqFail: begin
        if (d_q == '0) begin
          state_d = qta_pkg::SqDone;
        end else if (cur_c != 2'd3) begin
          state_d = qta_pkg::SqRead;
        end
      end
      qta_pkg::SqUp: begin
        state_d = (idx_q == '0) ? qta_pkg::SqDone : qta_pkg::SqChild;
      end
      qta_pkg::SqChild: begin
        if (k_q == 3'd4) state_d = qta_pkg::SqUp;
      end
      qta_pkg::SqDone: begin
        if (!rsp_stall_i) state_d = qta_pkg::SqIdle;
      end
      default: state_d = qta_pkg::SqIdle;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    status_d    = status_q;
    t_d         = t_q;
    d_d         = d_q;
    idx_d       = idx_q;
    node_d      = node_q;
    px_d        = px_q;
    py_d        = py_q;
    x_d         = x_q;
    y_d         = y_q;
    k_d         = k_q;
    acc_empty_d = acc_empty_q;
    acc_full_d  = acc_full_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = idx_q;
    mem_o.wdata = qta_pkg::FlagsEmpty;
    mem_o.raddr = idx_q;
    unique case (state_q)
      qta_pkg::SqClear: begin
        mem_o.we = 1'b1;
        idx_d    = (idx_q == IdxW'(qta_pkg::NodeCount - 1)) ? '0 : idx_q + IdxW'(1);
      end
      qta_pkg::SqIdle: begin
        if (accept) begin
          op_d   = req_i.op;
          t_d    = t_calc[DepthW-1:0];
          px_d   = req_i.pos_x;
          py_d   = req_i.pos_y;
          idx_d  = '0;
          d_d    = '0;
          x_d    = '0;
          y_d    = '0;
          node_d = '0;
          if (size_bad) begin
            status_d = qta_pkg::StBadSize;
          end else if (req_i.op == qta_pkg::OpRelease && misalign) begin
            status_d = qta_pkg::StNotAlloc;
          end else begin
            status_d = qta_pkg::StOk;
          end
        end
      end
      qta_pkg::SqDesc: begin
        if (!at_target) begin
          idx_d = IdxW'(child_base + (IdxW + 2)'(desc_c));
          d_d   = d_q + DepthW'(1);
        end
      end
      qta_pkg::SqRead: begin
      end
      qta_pkg::SqCheck: begin
        if (op_q == qta_pkg::OpAlloc) begin
          if (!fl_full && at_target && fl_empty) begin
            mem_o.we    = 1'b1;
            mem_o.wdata = qta_pkg::FlagsFull;
            node_d      = idx_q;
          end else if (!fl_full && !at_target) begin
            idx_d = IdxW'(child_base);
            d_d   = d_q + DepthW'(1);
          end
        end else if (fl_full) begin
          mem_o.we = 1'b1;
          node_d   = idx_q;
        end else begin
          status_d = qta_pkg::StNotAlloc;
        end
      end
      qta_pkg::SqFail: begin
        if (d_q == '0) begin
          status_d = qta_pkg::StNoSpace;
        end else if (cur_c != 2'd3) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          idx_d = parent;
          d_d   = d_q - DepthW'(1);
        end
      end
      qta_pkg::SqUp: begin
        if (idx_q != '0) begin
          if (op_q == qta_pkg::OpAlloc) begin
            x_d = cur_c[0] ? (x_q | half) : x_q;
            y_d = cur_c[1] ? (y_q | half) : y_q;
          end
          idx_d       = parent;
          d_d         = d_q - DepthW'(1);
          k_d         = '0;
          acc_empty_d = 1'b1;
          acc_full_d  = 1'b1;
        end
      end
      qta_pkg::SqChild: begin
        mem_o.raddr = IdxW'(child_base + (IdxW + 2)'(k_q[1:0]));
        if (k_q != '0) begin
          acc_empty_d = acc_empty_q & fl_empty;
          acc_full_d  = acc_full_q & fl_full;
        end
        if (k_q == 3'd4) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = {acc_full_q & fl_full, acc_empty_q & fl_empty};
        end
        k_d = k_q + 3'd1;
      end
      qta_pkg::SqDone: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qta_pkg::SqClear;
      idx_q   <= '0;
      d_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      d_q     <= d_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    status_q    <= status_d;
    t_q         <= t_d;
    node_q      <= node_d;
    px_q        <= px_d;
    py_q        <= py_d;
    x_q         <= x_d;
    y_q         <= y_d;
    acc_empty_q <= acc_empty_d;
    acc_full_q  <= acc_full_d;
  end

  assign req_stall_o      = (state_q != qta_pkg::SqIdle);
  assign rsp_valid_o      = (state_q == qta_pkg::SqDone);
  assign rsp_o.status     = status_q;
  assign rsp_o.res_x      = x_q;
  assign rsp_o.res_y      = y_q;
  assign rsp_o.node_index = 9'(node_q);

endmodule

`default_nettype wire

// File: rtl/core/qta_out_buf.sv
// Output register between the walker and the result channel.
// Depends on qta_pkg.
`default_nettype none

module qta_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire qta_pkg::rsp_t in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output qta_pkg::rsp_t      out_data_o,
  input  wire logic          out_stall_i
);

  logic          valid_q, valid_d;
  qta_pkg::rsp_t data_q, data_d;
  logic          load;

  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!valid_q || !out_stall_i) valid_d = in_valid_i;
    if (load) data_d = in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/qta_checker.sv
// Port-level checks of the quadtree atlas allocator, bound to its top level.
// Depends on qta_pkg and quadtree_atlas_allocator_top.
`default_nettype none

module qta_sva (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire qta_pkg::req_t in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire qta_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response transaction changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != qta_pkg::StOk |->
      out_data_o.res_x == '0 && out_data_o.res_y == '0 && out_data_o.node_index == '0)
    else $error("failed transaction carries nonzero result");

  a_ok_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == qta_pkg::StOk |->
      out_data_o.res_x[qta_pkg::MinNodeLog2-1:0] == '0 &&
      out_data_o.res_y[qta_pkg::MinNodeLog2-1:0] == '0)
    else $error("allocated corner off the node grid");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("request taken before flag sweep");

endmodule

bind quadtree_atlas_allocator_top qta_sva u_qta_sva (.*);

`default_nettype wire

// File: tb/qta_checker.sv
// Response checker for the quadtree atlas allocator: watches both channels,
// keeps its own copy of the node flag tree, predicts each response, compares.
// Depends on qta_pkg.
module qta_checker
  import qta_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_stall_i,
  input  req_t      in_data_i,
  input  wire logic out_valid_i,
  input  wire logic out_stall_i,
  input  rsp_t      out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  flags_t atlas_flags [NodeCount];
  rsp_t   rsp_due [$];

  function automatic void refresh_node(input int p);
    bit     all_empty;
    bit     all_full;
    flags_t f;
    all_empty = 1'b1;
    all_full  = 1'b1;
    if (p >= NodeCount) return;
    for (int k = 0; k < 4; k++) begin
      f = (p * 4 + 1 + k < NodeCount) ? atlas_flags[p * 4 + 1 + k] : '0;
      if ((f & FlagsEmpty) == '0) all_empty = 1'b0;
      if ((f & FlagsFull) == '0) all_full = 1'b0;
    end
    atlas_flags[p] = (all_empty ? FlagsEmpty : '0) | (all_full ? FlagsFull : '0);
  endfunction

  function automatic bit claim_region(input int idx, input int lg, input int x, input int y,
                                      input int tgt, output int ox, output int oy,
                                      output int oi);
    int half;
    int cx;
    int cy;
    if (idx >= NodeCount) return 1'b0;
    if ((atlas_flags[idx] & FlagsFull) != '0) return 1'b0;
    if (lg == tgt) begin
      if ((atlas_flags[idx] & FlagsEmpty) == '0) return 1'b0;
      atlas_flags[idx] = FlagsFull;
      ox = x;
      oy = y;
      oi = idx;
      return 1'b1;
    end
    if (lg <= tgt || lg <= MinNodeLog2) return 1'b0;
    half = 1 << (lg - 1);
    for (int c = 0; c < 4; c++) begin
      cx = x + (((c & 1) != 0) ? half : 0);
      cy = y + (((c & 2) != 0) ? half : 0);
      if (claim_region(idx * 4 + 1 + c, lg - 1, cx, cy, tgt, ox, oy, oi)) begin
        refresh_node(idx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t predict_rsp(input req_t r);
    rsp_t p;
    int   s;
    int   mask;
    int   idx;
    int   up;
    int   ox;
    int   oy;
    int   oi;
    p = '0;
    p.status = StOk;
    s = int'(r.req_size_log2);
    if (s < MinNodeLog2 || s > AtlasLog2) begin
      p.status = StBadSize;
    end else if (r.op == OpAlloc) begin
      if (claim_region(0, AtlasLog2, 0, 0, s, ox, oy, oi)) begin
        p.res_x      = ox[PosW-1:0];
        p.res_y      = oy[PosW-1:0];
        p.node_index = oi[8:0];
      end else begin
        p.status = StNoSpace;
      end
    end else begin
      mask = (1 << s) - 1;
      if ((int'(r.pos_x) >> AtlasLog2) != 0 || (int'(r.pos_y) >> AtlasLog2) != 0 ||
          (int'(r.pos_x) & mask) != 0 || (int'(r.pos_y) & mask) != 0) begin
        p.status = StNotAlloc;
      end else begin
        idx = 0;
        for (int lg = AtlasLog2; lg > s; lg--) begin
          idx = idx * 4 + 1 + int'({r.pos_y[lg-1], r.pos_x[lg-1]});
        end
        if (idx >= NodeCount || (atlas_flags[idx] & FlagsFull) == '0) begin
          p.status = StNotAlloc;
        end else begin
          atlas_flags[idx] = FlagsEmpty;
          up = idx;
          while (up != 0) begin
            up = (up - 1) / 4;
            refresh_node(up);
          end
          p.node_index = idx[8:0];
        end
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NodeCount; i++) atlas_flags[i] = FlagsEmpty;
      rsp_due.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rsp_due.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: unexpected response: status %0d x %0d y %0d node %0d", $time,
                   out_data_i.status, out_data_i.res_x, out_data_i.res_y,
                   out_data_i.node_index);
        end else begin
          want = rsp_due.pop_front();
          if (out_data_i.status !== want.status || out_data_i.res_x !== want.res_x ||
              out_data_i.res_y !== want.res_y ||
              out_data_i.node_index !== want.node_index) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: mismatch: expected status %0d x %0d y %0d node %0d", $time,
                     want.status, want.res_x, want.res_y, want.node_index);
            $display("%0t:          actual   status %0d x %0d y %0d node %0d", $time,
                     out_data_i.status, out_data_i.res_x, out_data_i.res_y,
                     out_data_i.node_index);
          end
        end
      end
      if (in_valid_i && !in_stall_i) rsp_due.push_back(predict_rsp(in_data_i));
    end
    pending_o = rsp_due.size();
  end

endmodule

// File: tb/tb_quadtree_atlas_allocator_top.sv
// Testbench top for the quadtree atlas allocator: clock, reset, directed and
// random allocate/release transactions, random idling on both channels.
// Depends on qta_pkg, qta_checker and the allocator RTL.
module tb_quadtree_atlas_allocator_top;
  import qta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;
  int   fail_count;
  int   pending;
  bit   calm = 1'b0;

  req_t sent_q [$];
  req_t live_regions [$];

  quadtree_atlas_allocator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  qta_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk_i) begin
    req_t issued;
    req_t held;
    if (rst_ni && out_valid_o && !out_stall_i && sent_q.size() > 0) begin
      issued = sent_q.pop_front();
      if (issued.op == OpAlloc && out_data_o.status == StOk) begin
        held.op            = OpRelease;
        held.req_size_log2 = issued.req_size_log2;
        held.pos_x         = out_data_o.res_x;
        held.pos_y         = out_data_o.res_y;
        live_regions.push_back(held);
      end
    end
  end

  task automatic send_req(input req_t r);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    sent_q.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input op_e op, input int s, input int x, input int y);
    req_t r;
    r.op            = op;
    r.req_size_log2 = s[SizeW-1:0];
    r.pos_x         = x[PosW-1:0];
    r.pos_y         = y[PosW-1:0];
    send_req(r);
  endtask

  function automatic req_t pick_random();
    req_t r;
    int   roll;
    int   w;
    int   s;
    int   v;
    int   mask;
    int   rel_pct;
    rel_pct = (live_regions.size() > 30) ? 55 : 25;
    roll    = $urandom_range(0, 99);
    r.pos_x = PosW'($urandom_range(0, 2047));
    r.pos_y = PosW'($urandom_range(0, 2047));
    if (roll < 8) begin
      v = $urandom_range(0, 10);
      s = (v < 7) ? v : v + 5;
      r.op = ($urandom_range(0, 1) != 0) ? OpRelease : OpAlloc;
      r.req_size_log2 = s[SizeW-1:0];
    end else if (roll < 16) begin
      s = $urandom_range(MinNodeLog2, AtlasLog2);
      mask = (1 << s) - 1;
      r.op = OpRelease;
      r.req_size_log2 = s[SizeW-1:0];
      if ($urandom_range(0, 1) != 0) begin
        r.pos_x = r.pos_x & ~PosW'(mask);
        r.pos_y = r.pos_y & ~PosW'(mask);
      end
    end else if (roll < 100 - rel_pct || live_regions.size() == 0) begin
      w = $urandom_range(0, 99);
      s = (w < 45) ? 7 : (w < 75) ? 8 : (w < 90) ? 9 : (w < 97) ? 10 : 11;
      r.op = OpAlloc;
      r.req_size_log2 = s[SizeW-1:0];
    end else begin
      v = $urandom_range(0, live_regions.size() - 1);
      r = live_regions[v];
      live_regions.delete(v);
    end
    return r;
  endfunction

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_fields(OpAlloc, 11, 0, 0);
    send_fields(OpAlloc, 7, 0, 0);
    send_fields(OpRelease, 7, 0, 0);
    send_fields(OpRelease, 11, 0, 0);
    send_fields(OpAlloc, 0, 2047, 2047);
    send_fields(OpAlloc, 6, 0, 0);
    send_fields(OpAlloc, 12, 0, 0);
    send_fields(OpAlloc, 15, 0, 0);
    send_fields(OpRelease, 15, 2047, 2047);
    send_fields(OpRelease, 6, 0, 0);
    repeat (4) send_fields(OpAlloc, 10, 0, 0);
    send_fields(OpAlloc, 7, 0, 0);
    send_fields(OpRelease, 11, 0, 0);
    send_fields(OpRelease, 10, 1024, 1024);
    send_fields(OpRelease, 10, 1024, 64);
    send_fields(OpAlloc, 7, 0, 0);
    send_fields(OpRelease, 7, 1920, 1920);
    send_fields(OpRelease, 7, 2047, 2047);
    send_fields(OpAlloc, 11, 0, 0);
    send_fields(OpRelease, 8, 1024, 1024);
    send_fields(OpRelease, 10, 0, 0);
    send_fields(OpRelease, 10, 1024, 0);

    for (int n = 0; n < 2000; n++) begin
      calm = (n >= 700 && n < 1000);
      send_req(pick_random());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_quadtree_atlas_allocator_top: PASS");
    end else begin
      $display("tb_quadtree_atlas_allocator_top: FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_quadtree_atlas_allocator_top: FAIL");
    $finish;
  end

endmodule
